@@ rtl/isap_pkg.sv @@
// ---------------------------------------------------------------------------
// ISAP package
// Shared types, constants and the Ascon round function for the ISAP engine.
// ---------------------------------------------------------------------------
package isap_pkg;

  // Full permutation state: five 64-bit words, word 0 is x0.
  typedef logic [4:0][63:0] perm_st_t;

  // Initialization vectors for the MAC, MAC re-key and encryption re-key.
  localparam logic [63:0] IV_MAC   = 64'h018040010C01060C;
  localparam logic [63:0] IV_KMAC  = 64'h028040010C01060C;
  localparam logic [63:0] IV_KENC  = 64'h038040010C01060C;
  localparam logic [63:0] PAD_TOP  = 64'h8000000000000000;
  localparam logic [63:0] DOM_SEP  = 64'h0000000000000001;
  localparam logic [3:0]  LAST_RND = 4'd11;
  localparam logic [3:0]  P6_START = 4'd6;
  localparam logic [6:0]  LAST_BIT = 7'd127;

  // Input word kinds.
  localparam logic [2:0] K_START_ENC = 3'd0;
  localparam logic [2:0] K_MSG       = 3'd1;
  localparam logic [2:0] K_START_MAC = 3'd2;
  localparam logic [2:0] K_AD        = 3'd3;
  localparam logic [2:0] K_CT        = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_KEY_UPPER = 1'b0;
  localparam logic CFG_KEY_LOWER = 1'b1;

  // Result kinds.
  localparam logic RES_CT  = 1'b0;
  localparam logic RES_TAG = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE, PH_ENC, PH_AD, PH_CT
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PERM, ST_BITS, ST_FIN, ST_ABS, ST_ABS_END, ST_EMIT_CT, ST_TAG
  } ctl_state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_ROUND, OP_LOAD_ENC, OP_LOAD_MAC, OP_REKEY_MAC,
    OP_ENC_FIN, OP_MAC_FIN, OP_AD_DONE, OP_EMIT_CT, OP_EMIT_TAG
  } dp_op_e;

  typedef enum logic [1:0] {
    INJ_NONE, INJ_BIT, INJ_ABS, INJ_PAD
  } inj_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    dp_op_e     op;
    inj_e       inj;
    logic [3:0] rnd;
    logic [6:0] bit_idx;
    logic       latch;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic last;
    logic slot_free;
  } dp_sts_t;

  function automatic logic [63:0] rotr(logic [63:0] v, int unsigned n);
    return (v >> n) | (v << (64 - n));
  endfunction

  // Byte mask keeping the top b bytes (b from 0 to 8).
  function automatic logic [63:0] byte_mask(logic [3:0] b);
    return ~(64'hFFFFFFFFFFFFFFFF >> {b, 3'b000});
  endfunction

  // One Ascon round with round index r (0 to 11).
  function automatic perm_st_t ascon_round(perm_st_t s, logic [3:0] r);
    logic [63:0] a0, a1, a2, a3, a4, t0, t1, t2, t3, t4;
    perm_st_t    o;
    a0 = s[0]; a1 = s[1]; a2 = s[2] ^ {56'd0, ~r, r}; a3 = s[3]; a4 = s[4];
    a0 = a0 ^ a4; a4 = a4 ^ a3; a2 = a2 ^ a1;
    t0 = a0 ^ (~a1 & a2);
    t1 = a1 ^ (~a2 & a3);
    t2 = a2 ^ (~a3 & a4);
    t3 = a3 ^ (~a4 & a0);
    t4 = a4 ^ (~a0 & a1);
    t1 = t1 ^ t0; t0 = t0 ^ t4; t3 = t3 ^ t2; t2 = ~t2;
    o[0] = t0 ^ rotr(t0, 19) ^ rotr(t0, 28);
    o[1] = t1 ^ rotr(t1, 61) ^ rotr(t1, 39);
    o[2] = t2 ^ rotr(t2, 1) ^ rotr(t2, 6);
    o[3] = t3 ^ rotr(t3, 10) ^ rotr(t3, 17);
    o[4] = t4 ^ rotr(t4, 7) ^ rotr(t4, 41);
    return o;
  endfunction

endpackage

@@ rtl/isap_datapath.sv @@
// ---------------------------------------------------------------------------
// ISAP datapath
// Permutation state, key, re-key buffers, round unit and result register.
// ---------------------------------------------------------------------------
module isap_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [63:0]       cfg_data_i,
  input  logic [63:0]       lane_i,
  input  logic [3:0]        lane_bytes_i,
  input  logic              last_i,
  input  logic [63:0]       nonce_upper_i,
  input  logic [63:0]       nonce_lower_i,
  input  isap_pkg::dp_cmd_t cmd_i,
  output isap_pkg::dp_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              result_kind_o,
  output logic [63:0]       out_lane_o,
  output logic [3:0]        out_bytes_o,
  output logic [63:0]       tag_upper_o,
  output logic [63:0]       tag_lower_o
);
  import isap_pkg::*;

  logic [63:0]  key_u_q, key_l_q;
  perm_st_t     s_q, s_d;
  perm_st_t     rnd_in;
  logic [127:0] y_q;
  logic [191:0] hold_q;
  logic [63:0]  lane_q;
  logic [3:0]   bytes_q;
  logic         last_q;
  logic [63:0]  inj;
  logic [63:0]  mask;
  logic         out_valid_q;
  logic         res_kind_q;
  logic [63:0]  res_lane_q, res_tu_q, res_tl_q;
  logic [3:0]   res_bytes_q;

  // Key registers, written by the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_u_q <= '0;
      key_l_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_KEY_UPPER) key_u_q <= cfg_data_i;
      else                            key_l_q <= cfg_data_i;
    end
  end

  assign mask = byte_mask(bytes_q);

  // Word folded into x0 ahead of a round.
  always_comb begin
    case (cmd_i.inj)
      INJ_BIT: inj = {y_q[~cmd_i.bit_idx], 63'd0};
      INJ_ABS: inj = bytes_q[3] ? lane_q
                                : ((lane_q & mask) | (PAD_TOP >> {bytes_q, 3'b000}));
      INJ_PAD: inj = PAD_TOP;
      default: inj = '0;
    endcase
    rnd_in    = s_q;
    rnd_in[0] = s_q[0] ^ inj;
  end

  // Next permutation state.
  always_comb begin
    s_d = s_q;
    case (cmd_i.op)
      OP_ROUND:     s_d = ascon_round(rnd_in, cmd_i.rnd);
      OP_LOAD_ENC:  s_d = {64'd0, 64'd0, IV_KENC, key_l_q, key_u_q};
      OP_LOAD_MAC:  s_d = {64'd0, 64'd0, IV_MAC, nonce_lower_i, nonce_upper_i};
      OP_REKEY_MAC: s_d = {64'd0, 64'd0, IV_KMAC, key_l_q, key_u_q};
      OP_ENC_FIN: begin
        s_d[3] = y_q[127:64];
        s_d[4] = y_q[63:0];
      end
      OP_MAC_FIN: begin
        s_d[2] = hold_q[191:128];
        s_d[3] = hold_q[127:64];
        s_d[4] = hold_q[63:0];
      end
      OP_AD_DONE:   s_d[4] = s_q[4] ^ DOM_SEP;
      default:      s_d = s_q;
    endcase
  end

  // State, re-key buffers and latched input word.
  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    if (cmd_i.op == OP_LOAD_ENC) y_q <= {nonce_upper_i, nonce_lower_i};
    if (cmd_i.op == OP_REKEY_MAC) begin
      y_q    <= {s_q[0], s_q[1]};
      hold_q <= {s_q[2], s_q[3], s_q[4]};
    end
    if (cmd_i.latch) begin
      lane_q  <= lane_i;
      bytes_q <= (lane_bytes_i > 4'd8) ? 4'd8 : lane_bytes_i;
      last_q  <= last_i;
    end
  end

  // Result register: a word waits here until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT_CT || cmd_i.op == OP_EMIT_TAG) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT_CT) begin
      res_kind_q  <= RES_CT;
      res_lane_q  <= (s_q[0] ^ lane_q) & mask;
      res_bytes_q <= bytes_q;
      res_tu_q    <= '0;
      res_tl_q    <= '0;
    end else if (cmd_i.op == OP_EMIT_TAG) begin
      res_kind_q  <= RES_TAG;
      res_lane_q  <= '0;
      res_bytes_q <= '0;
      res_tu_q    <= s_q[0];
      res_tl_q    <= s_q[1];
    end
  end

  assign sts_o.full      = bytes_q[3];
  assign sts_o.last      = last_q;
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = res_kind_q;
  assign out_lane_o    = res_lane_q;
  assign out_bytes_o   = res_bytes_q;
  assign tag_upper_o   = res_tu_q;
  assign tag_lower_o   = res_tl_q;

endmodule

@@ rtl/isap_ctrl.sv @@
// ---------------------------------------------------------------------------
// ISAP controller
// Sequences re-keying, permutation rounds, absorption and result output.
// ---------------------------------------------------------------------------
module isap_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        kind_i,
  input  isap_pkg::dp_sts_t sts_i,
  output isap_pkg::dp_cmd_t cmd_o
);
  import isap_pkg::*;

  ctl_state_e state_q, state_d, ret_q, ret_d;
  phase_e     phase_q, phase_d;
  logic [3:0] rnd_q, rnd_d;
  logic [6:0] bit_q, bit_d;
  logic       mac_q, mac_d, pad_q, pad_d;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      phase_q <= PH_IDLE;
      rnd_q   <= '0;
      bit_q   <= '0;
      mac_q   <= 1'b0;
      pad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      phase_q <= phase_d;
      rnd_q   <= rnd_d;
      bit_q   <= bit_d;
      mac_q   <= mac_d;
      pad_q   <= pad_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d       = state_q;
    ret_d         = ret_q;
    phase_d       = phase_q;
    rnd_d         = rnd_q;
    bit_d         = bit_q;
    mac_d         = mac_q;
    pad_d         = pad_q;
    in_ready_o    = 1'b0;
    cmd_o.op      = OP_NONE;
    cmd_o.inj     = INJ_NONE;
    cmd_o.rnd     = rnd_q;
    cmd_o.bit_idx = bit_q;
    cmd_o.latch   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          unique case (kind_i)
            K_START_ENC: begin
              cmd_o.op = OP_LOAD_ENC;
              mac_d    = 1'b0;
              bit_d    = '0;
              rnd_d    = '0;
              ret_d    = ST_BITS;
              state_d  = ST_PERM;
              phase_d  = PH_ENC;
            end
            K_START_MAC: begin
              cmd_o.op = OP_LOAD_MAC;
              rnd_d    = '0;
              ret_d    = ST_IDLE;
              state_d  = ST_PERM;
              phase_d  = PH_AD;
            end
            K_MSG: if (phase_q == PH_ENC) state_d = ST_EMIT_CT;
            K_AD: begin
              if (phase_q == PH_AD) begin
                pad_d   = 1'b0;
                state_d = ST_ABS;
              end
            end
            K_CT: begin
              if (phase_q == PH_CT) begin
                pad_d   = 1'b0;
                state_d = ST_ABS;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_PERM: begin
        cmd_o.op = OP_ROUND;
        rnd_d    = rnd_q + 4'd1;
        if (rnd_q == LAST_RND) state_d = ret_q;
      end
      ST_BITS: begin
        // One bit of the nonce (or, for MAC re-keying, of the hash) per round; the last bit opens a full permutation.
        cmd_o.op  = OP_ROUND;
        cmd_o.inj = INJ_BIT;
        if (bit_q == LAST_BIT) begin
          cmd_o.rnd = '0;
          rnd_d     = 4'd1;
          ret_d     = ST_FIN;
          state_d   = ST_PERM;
        end else begin
          cmd_o.rnd = LAST_RND;
          bit_d     = bit_q + 7'd1;
        end
      end
      ST_FIN: begin
        state_d = ST_PERM;
        if (mac_q) begin
          cmd_o.op = OP_MAC_FIN;
          rnd_d    = '0;
          ret_d    = ST_TAG;
        end else begin
          cmd_o.op = OP_ENC_FIN;
          rnd_d    = P6_START;
          ret_d    = ST_IDLE;
        end
      end
      ST_ABS: begin
        cmd_o.op  = OP_ROUND;
        cmd_o.inj = INJ_ABS;
        cmd_o.rnd = '0;
        rnd_d     = 4'd1;
        ret_d     = ST_ABS_END;
        state_d   = ST_PERM;
      end
      ST_ABS_END: begin
        if (sts_i.full && sts_i.last && !pad_q) begin
          // A full final word still needs a padding block.
          cmd_o.op  = OP_ROUND;
          cmd_o.inj = INJ_PAD;
          cmd_o.rnd = '0;
          rnd_d     = 4'd1;
          pad_d     = 1'b1;
          state_d   = ST_PERM;
        end else if (!sts_i.full || sts_i.last) begin
          if (phase_q == PH_AD) begin
            cmd_o.op = OP_AD_DONE;
            phase_d  = PH_CT;
            state_d  = ST_IDLE;
          end else begin
            cmd_o.op = OP_REKEY_MAC;
            mac_d    = 1'b1;
            bit_d    = '0;
            rnd_d    = '0;
            ret_d    = ST_BITS;
            state_d  = ST_PERM;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_CT: begin
        if (sts_i.slot_free) begin
          cmd_o.op = OP_EMIT_CT;
          if (sts_i.last || !sts_i.full) begin
            phase_d = PH_IDLE;
            state_d = ST_IDLE;
          end else begin
            rnd_d   = P6_START;
            ret_d   = ST_IDLE;
            state_d = ST_PERM;
          end
        end
      end
      ST_TAG: begin
        if (sts_i.slot_free) begin
          cmd_o.op = OP_EMIT_TAG;
          phase_d  = PH_IDLE;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // A result is only written into a free output slot.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_EMIT_CT || cmd_o.op == OP_EMIT_TAG) |-> sts_i.slot_free)
    else $error("result written while output slot is occupied");

  // The round counter never runs past the last round.
  a_rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PERM) |-> (rnd_q <= LAST_RND))
    else $error("round counter out of range");

  // A tag is only produced after MAC re-keying.
  a_tag_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAG) |-> mac_q)
    else $error("tag state reached outside MAC flow");

  // Bit injection ends in a full permutation that returns to finalization.
  a_bits_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BITS && bit_q == LAST_BIT) |=> (state_q == ST_PERM && ret_q == ST_FIN))
    else $error("re-key bit loop did not close correctly");

endmodule

@@ rtl/isap_aead_engine.sv @@
// ---------------------------------------------------------------------------
// ISAP-A-128a engine
// Authenticated encryption on the Ascon permutation, one round per cycle.
// ---------------------------------------------------------------------------
// Usage: write the key through cfg_we_i / cfg_idx_i / cfg_data_i while idle
// (index 0 upper half, index 1 lower half). Input words arrive on a
// valid/ready channel; kind selects start of encryption, message word,
// start of MAC, associated-data word or ciphertext word. Results leave on
// a valid/ready channel: a ciphertext word per message word, a tag at the
// end of the ciphertext stream.
// Steps, on the single round unit: start of encryption runs the full
// permutation, injects the nonce bit by bit, ends in a full permutation
// and the shortened one; a message word yields its result, then the
// shortened permutation unless final or partial; start of MAC and an
// absorbed word run the full permutation, one more to pad a full final word;
// the final ciphertext word adds re-keying and squeezing before the tag.
// Only one word is processed at a time; in_ready_o is high only while idle.
// A finished result sits in an output register; when the receiver stalls,
// the engine waits before writing the next result into it.
// Reset clears the key, the output valid and the mode back to idle.
module isap_aead_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [63:0] lane_i,
  input  logic [3:0]  lane_bytes_i,
  input  logic        last_i,
  input  logic [63:0] nonce_upper_i,
  input  logic [63:0] nonce_lower_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [63:0] out_lane_o,
  output logic [3:0]  out_bytes_o,
  output logic [63:0] tag_upper_o,
  output logic [63:0] tag_lower_o
);
  import isap_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer.
  isap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // State, round unit and result register.
  isap_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .lane_i        (lane_i),
    .lane_bytes_i  (lane_bytes_i),
    .last_i        (last_i),
    .nonce_upper_i (nonce_upper_i),
    .nonce_lower_i (nonce_lower_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .out_lane_o    (out_lane_o),
    .out_bytes_o   (out_bytes_o),
    .tag_upper_o   (tag_upper_o),
    .tag_lower_o   (tag_lower_o)
  );

endmodule
